/* rtl/yadif_pkg.sv */
package yadif_pkg;

  localparam int MAX_LINE_WIDTH   = 4096;
  localparam int LINE_WIDTH_RESET = 1920;

  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_LINE_WIDTH);
  localparam int HEAD_W     = COL_W + 1;
  localparam int WIN        = 7;
  localparam int DLY_STAGES = 3;
  localparam int SCORE_W    = PIX_W + 3;
  localparam int OUT_LAG    = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL_CHECK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 1'd1;

  localparam logic [1:0] FLUSH_IDLE = 2'd0;
  localparam logic [1:0] FLUSH_LAST = 2'd3;

  localparam int WIDTH_M1_RESET = (LINE_WIDTH_RESET > MAX_LINE_WIDTH) ?
                                  MAX_LINE_WIDTH - 1 : LINE_WIDTH_RESET - 1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  typedef struct packed {
    pix_t prev_above;
    pix_t prev_below;
    pix_t next_above;
    pix_t next_below;
    pix_t before_center;
    pix_t after_center;
    pix_t before_up2;
    pix_t before_down2;
    pix_t after_up2;
    pix_t after_down2;
  } field_set_t;

endpackage

/* rtl/yadif_col_if.sv */
interface yadif_col_if;
  logic            valid;
  logic            ready;
  yadif_pkg::pix_t cur_above;
  yadif_pkg::pix_t cur_below;
  yadif_pkg::pix_t prev_above;
  yadif_pkg::pix_t prev_below;
  yadif_pkg::pix_t next_above;
  yadif_pkg::pix_t next_below;
  yadif_pkg::pix_t before_center;
  yadif_pkg::pix_t after_center;
  yadif_pkg::pix_t before_up2;
  yadif_pkg::pix_t before_down2;
  yadif_pkg::pix_t after_up2;
  yadif_pkg::pix_t after_down2;

  modport source (
    output valid, cur_above, cur_below, prev_above, prev_below, next_above, next_below,
           before_center, after_center, before_up2, before_down2, after_up2, after_down2,
    input  ready
  );
  modport sink (
    input  valid, cur_above, cur_below, prev_above, prev_below, next_above, next_below,
           before_center, after_center, before_up2, before_down2, after_up2, after_down2,
    output ready
  );
endinterface

/* rtl/yadif_pix_if.sv */
interface yadif_pix_if;
  logic            valid;
  logic            ready;
  yadif_pkg::pix_t out_pixel;
  logic            end_of_line;

  modport source (output valid, out_pixel, end_of_line, input ready);
  modport sink (input valid, out_pixel, end_of_line, output ready);
endinterface

/* rtl/yadif_cfg_if.sv */
interface yadif_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [yadif_pkg::CFG_IDX_W-1:0]     index;
  logic [yadif_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/yadif_deinterlace_line_filter.sv */
// Pixel x comes from the request for column x+3 (or the last of a line), which passes
// through the input register, the shift/score register and the output register.
// Throughput: one request per cycle unless the output stalls; the last request of a line
// stays in the input register, with ready low until its last shift, while the window
// shifts out the three trailing pixels.
// Reset: synchronous active-high rst clears the pipeline valids, column position and
// config (spatial check off, width 1920); window and delay registers carry no reset.
module yadif_deinterlace_line_filter (
  input  logic        clk,
  input  logic        rst,
  yadif_col_if.sink   col,
  yadif_pix_if.source pix,
  yadif_cfg_if.sink   cfg
);

  typedef logic signed [yadif_pkg::PIX_W+1:0] sdiff_t;

  function automatic yadif_pkg::pix_t absdiff(input yadif_pkg::pix_t x, input yadif_pkg::pix_t y);
    absdiff = (x > y) ? x - y : y - x;
  endfunction

  function automatic yadif_pkg::pix_t avg(input yadif_pkg::pix_t x, input yadif_pkg::pix_t y);
    logic [yadif_pkg::PIX_W:0] s;
    s   = {1'b0, x} + {1'b0, y};
    avg = s[yadif_pkg::PIX_W:1];
  endfunction

  function automatic sdiff_t sx(input yadif_pkg::pix_t x);
    sx = $signed({2'b00, x});
  endfunction

  function automatic sdiff_t smax(input sdiff_t x, input sdiff_t y);
    smax = (x > y) ? x : y;
  endfunction

  function automatic sdiff_t smin(input sdiff_t x, input sdiff_t y);
    smin = (x < y) ? x : y;
  endfunction

  function automatic yadif_pkg::score_t score3(
    input yadif_pkg::pix_t a0, input yadif_pkg::pix_t b0,
    input yadif_pkg::pix_t a1, input yadif_pkg::pix_t b1,
    input yadif_pkg::pix_t a2, input yadif_pkg::pix_t b2);
    logic [yadif_pkg::PIX_W+1:0] s;
    s = {2'b00, absdiff(a0, b0)} + {2'b00, absdiff(a1, b1)} + {2'b00, absdiff(a2, b2)};
    score3 = $signed({1'b0, s});
  endfunction

  // config
  logic                          spatial_en;
  logic [yadif_pkg::COL_W-1:0]   width_m1;

  // input register
  logic                          ireg_v;
  yadif_pkg::pix_t               ireg_above;
  yadif_pkg::pix_t               ireg_below;
  yadif_pkg::field_set_t         ireg_f;

  // line sequencing
  logic [yadif_pkg::COL_W-1:0]   colpos;
  logic [yadif_pkg::HEAD_W-1:0]  head;
  logic [1:0]                    flush_step;

  // window and field delay
  yadif_pkg::pix_t               above_win [yadif_pkg::WIN];
  yadif_pkg::pix_t               below_win [yadif_pkg::WIN];
  yadif_pkg::pix_t               an [yadif_pkg::WIN];
  yadif_pkg::pix_t               bn [yadif_pkg::WIN];
  yadif_pkg::field_set_t         dly [yadif_pkg::DLY_STAGES];

  // score stage
  logic                          p_v;
  logic                          p_eol;
  yadif_pkg::score_t             p_s_c, p_s_m1, p_s_m2, p_s_p1, p_s_p2;
  yadif_pkg::pix_t               p_pred_c, p_pred_m1, p_pred_m2, p_pred_p1, p_pred_p2;
  yadif_pkg::pix_t               p_d;
  yadif_pkg::pix_t               p_diff;

  // output register
  logic                          out_v;
  yadif_pkg::pix_t               out_px;
  logic                          out_eol;

  logic                          q_adv, p_adv, shift_en, consume;
  logic                          line_end, fill, emit, eol;
  logic [yadif_pkg::HEAD_W-1:0]  head_now;

  yadif_pkg::pix_t               a_c, a_e, a_d, a_diff, a_diff0;
  yadif_pkg::score_t             a_s_c;
  yadif_pkg::pix_t               b_res;

  assign q_adv    = !out_v || pix.ready;
  assign p_adv    = !p_v || q_adv;
  assign shift_en = ireg_v && p_adv;

  always_comb begin
    line_end = colpos >= width_m1;
    fill     = (flush_step == yadif_pkg::FLUSH_IDLE) && (colpos == '0);
    if (flush_step == yadif_pkg::FLUSH_IDLE) begin
      head_now = line_end ? yadif_pkg::HEAD_W'(width_m1) : yadif_pkg::HEAD_W'(colpos);
    end else begin
      head_now = head + 1'b1;
    end
    emit    = head_now >= yadif_pkg::HEAD_W'(yadif_pkg::OUT_LAG);
    eol     = head_now == yadif_pkg::HEAD_W'(width_m1) + yadif_pkg::HEAD_W'(yadif_pkg::OUT_LAG);
    consume = shift_en && (((flush_step == yadif_pkg::FLUSH_IDLE) && !line_end) ||
                           (flush_step == yadif_pkg::FLUSH_LAST));
  end

  assign col.ready = !ireg_v || consume;
  assign cfg.ready = 1'b1;

  // window after this shift; a new line starts with the edge pixel everywhere
  always_comb begin
    for (int i = 0; i < yadif_pkg::WIN - 1; i++) begin
      an[i] = fill ? ireg_above : above_win[i+1];
      bn[i] = fill ? ireg_below : below_win[i+1];
    end
    an[yadif_pkg::WIN-1] = ireg_above;
    bn[yadif_pkg::WIN-1] = ireg_below;
  end

  // temporal terms and optional spatial check
  always_comb begin
    yadif_pkg::field_set_t f;
    yadif_pkg::pix_t       t0, t1, t2, sb, sf;
    logic [yadif_pkg::PIX_W:0] sum9;
    sdiff_t de, dc, bcm, fe, hi, lo, dx;
    f       = dly[yadif_pkg::DLY_STAGES-1];
    a_c     = an[3];
    a_e     = bn[3];
    a_d     = avg(f.before_center, f.after_center);
    t0      = absdiff(f.before_center, f.after_center) >> 1;
    sum9    = {1'b0, absdiff(f.prev_above, a_c)} + {1'b0, absdiff(f.prev_below, a_e)};
    t1      = sum9[yadif_pkg::PIX_W:1];
    sum9    = {1'b0, absdiff(f.next_above, a_c)} + {1'b0, absdiff(f.next_below, a_e)};
    t2      = sum9[yadif_pkg::PIX_W:1];
    a_diff0 = (t0 > t1) ? t0 : t1;
    a_diff0 = (a_diff0 > t2) ? a_diff0 : t2;
    sb      = avg(f.before_up2, f.after_up2);
    sf      = avg(f.before_down2, f.after_down2);
    de      = sx(a_d) - sx(a_e);
    dc      = sx(a_d) - sx(a_c);
    bcm     = sx(sb) - sx(a_c);
    fe      = sx(sf) - sx(a_e);
    hi      = smax(smax(de, dc), smin(bcm, fe));
    lo      = smin(smin(de, dc), smax(bcm, fe));
    dx      = smax(smax(sx(a_diff0), lo), -hi);
    a_diff  = spatial_en ? dx[yadif_pkg::PIX_W-1:0] : a_diff0;
    a_s_c   = score3(an[2], bn[2], an[3], bn[3], an[4], bn[4]) - yadif_pkg::score_t'(1);
  end

  // direction search and clamp
  always_comb begin
    yadif_pkg::score_t best;
    yadif_pkg::pix_t   pred;
    logic [yadif_pkg::PIX_W:0] hi_b;
    sdiff_t lo_b;
    best = p_s_c;
    pred = p_pred_c;
    if (p_s_m1 < best) begin
      best = p_s_m1;
      pred = p_pred_m1;
      if (p_s_m2 < best) begin
        best = p_s_m2;
        pred = p_pred_m2;
      end
    end
    if (p_s_p1 < best) begin
      best = p_s_p1;
      pred = p_pred_p1;
      if (p_s_p2 < best) begin
        best = p_s_p2;
        pred = p_pred_p2;
      end
    end
    hi_b = {1'b0, p_d} + {1'b0, p_diff};
    lo_b = sx(p_d) - sx(p_diff);
    if ({1'b0, pred} > hi_b) begin
      b_res = hi_b[yadif_pkg::PIX_W-1:0];
    end else if (sx(pred) < lo_b) begin
      b_res = lo_b[yadif_pkg::PIX_W-1:0];
    end else begin
      b_res = pred;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      spatial_en <= 1'b0;
      width_m1   <= yadif_pkg::COL_W'(yadif_pkg::WIDTH_M1_RESET);
      ireg_v     <= 1'b0;
      colpos     <= '0;
      head       <= '0;
      flush_step <= yadif_pkg::FLUSH_IDLE;
      p_v        <= 1'b0;
      out_v      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          yadif_pkg::CFG_SPATIAL_CHECK: begin
            spatial_en <= cfg.data[0];
          end
          yadif_pkg::CFG_LINE_WIDTH: begin
            if (cfg.data == '0) begin
              width_m1 <= '0;
            end else if (32'(cfg.data) > 32'(yadif_pkg::MAX_LINE_WIDTH)) begin
              width_m1 <= yadif_pkg::COL_W'(yadif_pkg::MAX_LINE_WIDTH - 1);
            end else begin
              width_m1 <= yadif_pkg::COL_W'(cfg.data - 1'b1);
            end
          end
          default: begin
          end
        endcase
      end

      if (col.valid && col.ready) begin
        ireg_v <= 1'b1;
      end else if (consume) begin
        ireg_v <= 1'b0;
      end

      if (shift_en) begin
        head <= head_now;
        if (flush_step == yadif_pkg::FLUSH_IDLE) begin
          if (line_end) begin
            flush_step <= flush_step + 1'b1;
          end else begin
            colpos <= colpos + 1'b1;
          end
        end else if (flush_step == yadif_pkg::FLUSH_LAST) begin
          flush_step <= yadif_pkg::FLUSH_IDLE;
          colpos     <= '0;
        end else begin
          flush_step <= flush_step + 1'b1;
        end
      end

      if (p_adv) begin
        p_v <= shift_en && emit;
      end
      if (q_adv) begin
        out_v <= p_v;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (col.valid && col.ready) begin
      ireg_above           <= col.cur_above;
      ireg_below           <= col.cur_below;
      ireg_f.prev_above    <= col.prev_above;
      ireg_f.prev_below    <= col.prev_below;
      ireg_f.next_above    <= col.next_above;
      ireg_f.next_below    <= col.next_below;
      ireg_f.before_center <= col.before_center;
      ireg_f.after_center  <= col.after_center;
      ireg_f.before_up2    <= col.before_up2;
      ireg_f.before_down2  <= col.before_down2;
      ireg_f.after_up2     <= col.after_up2;
      ireg_f.after_down2   <= col.after_down2;
    end

    if (shift_en) begin
      above_win <= an;
      below_win <= bn;
      dly[0]    <= ireg_f;
      for (int s = 1; s < yadif_pkg::DLY_STAGES; s++) begin
        dly[s] <= dly[s-1];
      end
      p_eol     <= eol;
      p_d       <= a_d;
      p_diff    <= a_diff;
      p_s_c     <= a_s_c;
      p_s_m1    <= score3(an[1], bn[3], an[2], bn[4], an[3], bn[5]);
      p_s_m2    <= score3(an[0], bn[4], an[1], bn[5], an[2], bn[6]);
      p_s_p1    <= score3(an[3], bn[1], an[4], bn[2], an[5], bn[3]);
      p_s_p2    <= score3(an[4], bn[0], an[5], bn[1], an[6], bn[2]);
      p_pred_c  <= avg(a_c, a_e);
      p_pred_m1 <= avg(an[2], bn[4]);
      p_pred_m2 <= avg(an[1], bn[5]);
      p_pred_p1 <= avg(an[4], bn[2]);
      p_pred_p2 <= avg(an[5], bn[1]);
    end

    if (q_adv && p_v) begin
      out_px  <= b_res;
      out_eol <= p_eol;
    end
  end

  assign pix.valid       = out_v;
  assign pix.out_pixel   = out_px;
  assign pix.end_of_line = out_eol;

`ifndef ASSERT_OFF
  a_flush_holds_request: assert property (@(posedge clk) disable iff (rst)
    (flush_step != yadif_pkg::FLUSH_IDLE) |-> ireg_v)
    else $error("line flush running without a held request");

  a_flush_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (flush_step != yadif_pkg::FLUSH_IDLE && flush_step != yadif_pkg::FLUSH_LAST)
      |-> !col.ready)
    else $error("input taken in the middle of a line flush");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !pix.valid)
    else $error("output valid after reset");

  a_no_stall_shift: assert property (@(posedge clk) disable iff (rst)
    (p_v && !q_adv) |-> !shift_en)
    else $error("window shifted while score stage is stalled");
`endif

endmodule
